>>> hw/rtl/imuoc_pkg.sv
// ----------------------------------------------------------------------------
// imuoc_pkg
// Shared constants for the IMU offset calibration and correction block.
// ----------------------------------------------------------------------------
package imuoc_pkg;

   localparam int CAL_SAMPLES_LOG2 = 7;
   localparam int SAMPLE_W         = 16;
   localparam int SUM_W            = SAMPLE_W + CAL_SAMPLES_LOG2;
   localparam int CNT_W            = CAL_SAMPLES_LOG2;
   localparam int MAG_SHIFT        = 5;
   localparam int PROD_W           = 2 * SAMPLE_W + 1;
   localparam int KIND_W           = 2;
   localparam int CSR_INDEX_W      = 3;
   localparam int TDATA_W          = 3 * SAMPLE_W;
   localparam int TUSER_W          = KIND_W + 1;

   localparam logic signed [SAMPLE_W-1:0] ONE_G          = 16'sd4096;
   localparam logic signed [SAMPLE_W-1:0] MAG_SCALE_UNITY = 16'sd32;

   localparam logic [KIND_W-1:0] KIND_ACCEL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GYRO  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MAG   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_MAG_OFFSET_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAG_OFFSET_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAG_OFFSET_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAG_SCALE_X  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAG_SCALE_Y  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MAG_SCALE_Z  = 3'd5;

endpackage

>>> hw/rtl/imu_offset_calibration_correction.sv
// ----------------------------------------------------------------------------
// imu_offset_calibration_correction
// Bias averaging and offset correction for 3-axis accel and gyro samples; offset and scale correction for mag.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one raw sample per transfer. tuser = {calibrate, kind}, tdata =
//            {z, y, x}. Accel/gyro samples with calibrate set are summed; every
//            128th such sample of a sensor loads new offsets and returns them.
//   rsp_*  : tuser = {calibration_done, sensor}, tdata = {z, y, x}: either a
//            corrected sample or the new offsets. Accumulating samples and
//            kind 3 return nothing.
//   csr_*  : magnetometer offset and scale registers, written while idle.
// A req transfer passes through an input register, then one pass of adders and
// one 17x16 multiplier per axis into the result register, which drives
// rsp_tvalid. Throughput is one sample per cycle while rsp_tready is high.
// Reset clears sums, counts and accel/gyro offsets, sets mag offsets to 0 and
// mag scales to unity (32). When rsp_tready is held low the result register
// and input register fill, then req_tready drops until the result leaves.
// ----------------------------------------------------------------------------
module imu_offset_calibration_correction (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [imuoc_pkg::TDATA_W-1:0]         req_tdata,  // sample_x, sample_y, sample_z
   input  logic [imuoc_pkg::TUSER_W-1:0]         req_tuser,  // kind[1:0], calibrate
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [imuoc_pkg::TDATA_W-1:0]         rsp_tdata,  // out_x, out_y, out_z
   output logic [imuoc_pkg::TUSER_W-1:0]         rsp_tuser,  // sensor[1:0], calibration_done
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [imuoc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [imuoc_pkg::SAMPLE_W-1:0]        csr_data
);
   import imuoc_pkg::*;

   // input stage
   logic                       in_valid_ff;
   logic [KIND_W-1:0]          in_kind_ff;
   logic                       in_cal_ff;
   logic signed [SAMPLE_W-1:0] in_s_ff [3];

   // calibration state
   logic signed [SUM_W-1:0]    accel_sum_ff [3];
   logic signed [SUM_W-1:0]    gyro_sum_ff  [3];
   logic [CNT_W-1:0]           accel_cnt_ff;
   logic [CNT_W-1:0]           gyro_cnt_ff;
   logic signed [SAMPLE_W-1:0] accel_off_ff [3];
   logic signed [SAMPLE_W-1:0] gyro_off_ff  [3];
   logic signed [SAMPLE_W-1:0] mag_off_ff   [3];
   logic signed [SAMPLE_W-1:0] mag_scale_ff [3];

   // result stage
   logic                       rsp_valid_ff;
   logic [KIND_W-1:0]          rsp_kind_ff;
   logic                       rsp_done_ff;
   logic signed [SAMPLE_W-1:0] rsp_out_ff [3];

   logic                       out_free;
   logic                       advance;
   logic                       is_accel;
   logic                       is_imu;
   logic                       cnt_full;
   logic                       cal_step;
   logic                       produce_in;
   logic                       done_in;
   logic [CNT_W-1:0]           cnt_sel;
   logic signed [SUM_W-1:0]    sum_sel  [3];
   logic signed [SUM_W-1:0]    sum_add  [3];
   logic signed [SAMPLE_W-1:0] off_sel  [3];
   logic signed [SAMPLE_W-1:0] new_off  [3];
   logic signed [SAMPLE_W-1:0] corr     [3];
   logic signed [SAMPLE_W-1:0] mag_s    [3];
   logic signed [SAMPLE_W:0]   mag_diff [3];
   logic signed [PROD_W-1:0]   mag_prod [3];
   logic signed [SAMPLE_W-1:0] out_in   [3];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_done_ff, rsp_kind_ff};
   assign rsp_tdata  = {rsp_out_ff[2], rsp_out_ff[1], rsp_out_ff[0]};

   always_comb begin
      is_accel = (in_kind_ff == KIND_ACCEL);
      is_imu   = is_accel || (in_kind_ff == KIND_GYRO);
      cnt_sel  = is_accel ? accel_cnt_ff : gyro_cnt_ff;
      cnt_full = &cnt_sel;
      cal_step = advance && is_imu && in_cal_ff;
      mag_s[0] = in_s_ff[0];
      mag_s[1] = in_s_ff[1];
      mag_s[2] = -in_s_ff[2];
      for (int i = 0; i < 3; i++) begin
         sum_sel[i]  = is_accel ? accel_sum_ff[i] : gyro_sum_ff[i];
         off_sel[i]  = is_accel ? accel_off_ff[i] : gyro_off_ff[i];
         sum_add[i]  = sum_sel[i] + {{CAL_SAMPLES_LOG2{in_s_ff[i][SAMPLE_W-1]}}, in_s_ff[i]};
         new_off[i]  = sum_add[i][SUM_W-1:CAL_SAMPLES_LOG2];
         corr[i]     = in_s_ff[i] - off_sel[i];
         mag_diff[i] = {mag_s[i][SAMPLE_W-1], mag_s[i]}
                     - {mag_off_ff[i][SAMPLE_W-1], mag_off_ff[i]};
         mag_prod[i] = mag_diff[i] * mag_scale_ff[i];
      end
      if (is_accel) begin
         new_off[2] = new_off[2] - ONE_G;
      end
      done_in    = 1'b0;
      produce_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         out_in[i] = corr[i];
      end
      case (in_kind_ff)
         KIND_ACCEL, KIND_GYRO: begin
            if (in_cal_ff) begin
               produce_in = cnt_full;
               done_in    = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  out_in[i] = new_off[i];
               end
            end else begin
               produce_in = 1'b1;
            end
         end
         KIND_MAG: begin
            produce_in = 1'b1;
            for (int i = 0; i < 3; i++) begin
               out_in[i] = mag_prod[i][MAG_SHIFT+SAMPLE_W-1:MAG_SHIFT];
            end
         end
         default: begin
            produce_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         accel_cnt_ff <= '0;
         gyro_cnt_ff  <= '0;
         for (int i = 0; i < 3; i++) begin
            accel_sum_ff[i] <= '0;
            gyro_sum_ff[i]  <= '0;
            accel_off_ff[i] <= '0;
            gyro_off_ff[i]  <= '0;
            mag_off_ff[i]   <= '0;
            mag_scale_ff[i] <= MAG_SCALE_UNITY;
         end
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= advance && produce_in;
         end
         if (cal_step) begin
            if (is_accel) begin
               accel_cnt_ff <= cnt_sel + 1'b1;
            end else begin
               gyro_cnt_ff <= cnt_sel + 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
               if (is_accel) begin
                  accel_sum_ff[i] <= cnt_full ? '0 : sum_add[i];
                  if (cnt_full) begin
                     accel_off_ff[i] <= new_off[i];
                  end
               end else begin
                  gyro_sum_ff[i] <= cnt_full ? '0 : sum_add[i];
                  if (cnt_full) begin
                     gyro_off_ff[i] <= new_off[i];
                  end
               end
            end
         end
         if (csr_valid) begin
            unique case (csr_index)
               REG_MAG_OFFSET_X: mag_off_ff[0]   <= csr_data;
               REG_MAG_OFFSET_Y: mag_off_ff[1]   <= csr_data;
               REG_MAG_OFFSET_Z: mag_off_ff[2]   <= csr_data;
               REG_MAG_SCALE_X:  mag_scale_ff[0] <= csr_data;
               REG_MAG_SCALE_Y:  mag_scale_ff[1] <= csr_data;
               REG_MAG_SCALE_Z:  mag_scale_ff[2] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser[KIND_W-1:0];
         in_cal_ff  <= req_tuser[KIND_W];
         for (int i = 0; i < 3; i++) begin
            in_s_ff[i] <= req_tdata[i*SAMPLE_W +: SAMPLE_W];
         end
      end
      if (advance) begin
         rsp_kind_ff <= in_kind_ff;
         rsp_done_ff <= done_in;
         for (int i = 0; i < 3; i++) begin
            rsp_out_ff[i] <= out_in[i];
         end
      end
   end

   // completing an accel set returns offsets and restarts the count
   a_accel_done: assert property (@(posedge clock) disable iff (reset)
      (advance && in_kind_ff == KIND_ACCEL && in_cal_ff && cnt_full)
      |=> (rsp_tvalid && rsp_tuser[KIND_W] && accel_cnt_ff == '0))
      else $error("accel calibration set did not complete");

   // accumulating samples produce no transfer
   a_accum_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && is_imu && in_cal_ff && !cnt_full) |=> !rsp_tvalid)
      else $error("accumulating sample produced a result");

   // magnetometer samples leave the accel and gyro state alone
   a_mag_state: assert property (@(posedge clock) disable iff (reset)
      (advance && in_kind_ff == KIND_MAG)
      |=> ($stable(accel_cnt_ff) && $stable(gyro_cnt_ff)
           && $stable(accel_sum_ff[0]) && $stable(gyro_sum_ff[0])))
      else $error("magnetometer sample changed calibration state");

   // a stalled result is never overwritten by a new one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !advance)
      else $error("result register overwritten while stalled");

endmodule
